// File: hw/rtl/c2d_pkg.sv
// shared constants, types and codes for the 2d zero-padded convolution block
package c2d_pkg;

    // image store geometry (square, power-of-two side)
    localparam int IMG_AW        = 6;
    localparam int MAX_IMAGE_DIM = 1 << IMG_AW;
    localparam int IMG_DEPTH     = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
    localparam int IMG_ADDR_W    = 2 * IMG_AW;
    localparam int DIM_W         = IMG_AW + 1;
    localparam int POS_W         = IMG_AW + 2;

    // kernel store geometry
    localparam int MAX_KERNEL_DIM = 7;
    localparam int KDIM_W         = $clog2(MAX_KERNEL_DIM + 1);
    localparam int KER_DEPTH      = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
    localparam int KER_ADDR_W     = $clog2(KER_DEPTH);

    // arithmetic widths
    localparam int SAMPLE_BITS = 16;
    localparam int VALUE_W     = 16;
    localparam int TAP_W       = 16;
    localparam int PROD_W      = SAMPLE_BITS + TAP_W;
    localparam int SUM_W       = 37;

    // field widths
    localparam int FUNC_W = 2;
    localparam int ROW_W  = 6;
    localparam int CFG_IDX_W = 2;

    // function codes
    typedef logic [FUNC_W-1:0] t_func;
    localparam t_func FUNC_WR_IMG = 2'd0;
    localparam t_func FUNC_WR_TAP = 2'd1;
    localparam t_func FUNC_QUERY  = 2'd2;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_KERNEL_COLS  = 2'd2;
    localparam t_cfg_idx CFG_KERNEL_ROWS  = 2'd3;

    // query sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // control riding along with each kernel position into the mac
    typedef struct packed {
        logic step;   // a kernel position occupies this slot
        logic vld;    // position lies inside the image
        logic first;  // first position of the query
        logic last;   // last position of the query
    } t_mac_ctl;

endpackage

// File: hw/rtl/c2d_ram.sv
// generic single-write, single-read ram with registered read data
module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/c2d_mac.sv
// shared multiply-accumulate: registered product, then 37-bit accumulate
module c2d_mac
    import c2d_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_ctl                      i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [TAP_W-1:0]       i_tap,
    output logic signed [SUM_W-1:0]       o_sum,
    output logic                          o_done
);

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_ctl;
    logic signed [SUM_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]  n_acc;
    logic signed [SUM_W-1:0]  addend;
    logic                     r_done;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_tap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_done <= r_ctl.step & r_ctl.last;
        end
    end

    // positions outside the image add nothing
    always_comb begin
        addend = r_ctl.vld ? SUM_W'(r_prod) : '0;
        n_acc  = (r_ctl.first ? '0 : r_acc) + addend;
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (r_ctl.step) begin
            r_acc <= n_acc;
        end
    end

    assign o_sum  = r_acc;
    assign o_done = r_done;

endmodule

// File: hw/rtl/conv2d_zero_padded.sv
// top level: stores, query sequencer and result register of the 2d convolution
//
//  channel  direction  handshake                 payload
//  s        in         i_s_tvalid / o_s_tready   i_s_tdata, i_s_tuser (func)
//  m        out        o_m_tvalid / i_m_tready   o_m_tdata, o_m_tuser (position_ok)
//  cfg      in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  a query inside the image is paced by the single mac walking one
//  kernel position per cycle out of the image and kernel rams, followed
//  by the registered read, multiply and accumulate. a query outside the
//  image skips the walk and goes straight to emit.
//  reset (synchronous, active low) clears control and sets 64, 64, 3, 3;
//  the stores are not cleared. a held result stalls the next query at emit, and input with it.
module conv2d_zero_padded
    import c2d_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [31:0]          i_s_tdata,  // row[5:0], col[11:6], value[27:12], zero pad
    input  logic [FUNC_W-1:0]    i_s_tuser,  // func[1:0]
    // master stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [55:0]          o_m_tdata,  // sum[36:0], out_row[42:37], out_col[48:43], pad
    output logic [0:0]           o_m_tuser,  // position_ok[0]
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    // input fields
    t_func                       s_func;
    logic [ROW_W-1:0]            s_row;
    logic [ROW_W-1:0]            s_col;
    logic [VALUE_W-1:0]          s_value;
    logic                        s_acc;

    assign s_func  = i_s_tuser;
    assign s_row   = i_s_tdata[ROW_W-1:0];
    assign s_col   = i_s_tdata[2*ROW_W-1:ROW_W];
    assign s_value = i_s_tdata[2*ROW_W+VALUE_W-1:2*ROW_W];
    assign s_acc   = i_s_tvalid & o_s_tready;

    // clamped configuration
    logic [DIM_W-1:0]  r_img_w;
    logic [DIM_W-1:0]  r_img_h;
    logic [KDIM_W-1:0] r_ker_c;
    logic [KDIM_W-1:0] r_ker_r;
    logic [DIM_W-1:0]  cfg_dim;
    logic [KDIM_W-1:0] cfg_kdim;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_dim = DIM_W'(1);
        end else if (int'(i_cfg_data) > MAX_IMAGE_DIM) begin
            cfg_dim = DIM_W'(MAX_IMAGE_DIM);
        end else begin
            cfg_dim = i_cfg_data;
        end
        if (i_cfg_data[KDIM_W-1:0] == '0) begin
            cfg_kdim = KDIM_W'(1);
        end else if (int'(i_cfg_data[KDIM_W-1:0]) > MAX_KERNEL_DIM) begin
            cfg_kdim = KDIM_W'(MAX_KERNEL_DIM);
        end else begin
            cfg_kdim = i_cfg_data[KDIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= DIM_W'(64);
            r_img_h <= DIM_W'(64);
            r_ker_c <= KDIM_W'(3);
            r_ker_r <= KDIM_W'(3);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_img_w <= cfg_dim;
                CFG_IMAGE_HEIGHT: r_img_h <= cfg_dim;
                CFG_KERNEL_COLS:  r_ker_c <= cfg_kdim;
                CFG_KERNEL_ROWS:  r_ker_r <= cfg_kdim;
                default: ;
            endcase
        end
    end

    // store writes
    logic img_we;
    logic tap_we;
    logic [IMG_ADDR_W-1:0] img_waddr;
    logic [KER_ADDR_W-1:0] tap_waddr;

    assign img_we = s_acc && (s_func == FUNC_WR_IMG) &&
                    (int'(s_row) < MAX_IMAGE_DIM) && (int'(s_col) < MAX_IMAGE_DIM);
    assign tap_we = s_acc && (s_func == FUNC_WR_TAP) &&
                    (int'(s_row) < MAX_KERNEL_DIM) && (int'(s_col) < MAX_KERNEL_DIM);
    assign img_waddr = {s_row[IMG_AW-1:0], s_col[IMG_AW-1:0]};
    assign tap_waddr = KER_ADDR_W'(int'(s_row) * MAX_KERNEL_DIM + int'(s_col));

    // query sequencer
    t_state            r_state;
    t_state            n_state;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  r_col;
    logic              r_ok;
    logic [KDIM_W-1:0] r_kx;
    logic [KDIM_W-1:0] r_ky;
    logic              q_ok;
    logic              walk_last;
    logic              mac_done;
    logic signed [SUM_W-1:0] mac_sum;
    logic              out_free;

    assign q_ok = ({1'b0, s_row} < r_img_h) && ({1'b0, s_col} < r_img_w);
    assign walk_last = (r_kx == r_ker_c - 1'b1) && (r_ky == r_ker_r - 1'b1);
    assign out_free  = !o_m_tvalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid && s_func == FUNC_QUERY) begin
                    n_state = q_ok ? ST_WALK : ST_EMIT;
                end
            end
            ST_WALK: begin
                if (walk_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // query latch and kernel position counters
    always_ff @(posedge i_clk) begin
        if (s_acc && s_func == FUNC_QUERY) begin
            r_row <= s_row;
            r_col <= s_col;
            r_ok  <= q_ok;
            r_kx  <= '0;
            r_ky  <= '0;
        end else if (r_state == ST_WALK) begin
            if (r_kx == r_ker_c - 1'b1) begin
                r_kx <= '0;
                r_ky <= r_ky + 1'b1;
            end else begin
                r_kx <= r_kx + 1'b1;
            end
        end
    end

    // image position under the current tap
    logic signed [POS_W-1:0] iy;
    logic signed [POS_W-1:0] ix;
    logic                    pos_in;
    logic [IMG_ADDR_W-1:0]   img_raddr;
    logic [KER_ADDR_W-1:0]   tap_raddr;

    always_comb begin
        iy = $signed({{(POS_W-ROW_W){1'b0}}, r_row}) +
             $signed({{(POS_W-KDIM_W){1'b0}}, r_ky}) -
             $signed({{(POS_W-KDIM_W+1){1'b0}}, r_ker_r[KDIM_W-1:1]});
        ix = $signed({{(POS_W-ROW_W){1'b0}}, r_col}) +
             $signed({{(POS_W-KDIM_W){1'b0}}, r_kx}) -
             $signed({{(POS_W-KDIM_W+1){1'b0}}, r_ker_c[KDIM_W-1:1]});
        pos_in = !iy[POS_W-1] && (iy[POS_W-2:0] < r_img_h) &&
                 !ix[POS_W-1] && (ix[POS_W-2:0] < r_img_w);
        img_raddr = {iy[IMG_AW-1:0], ix[IMG_AW-1:0]};
        tap_raddr = KER_ADDR_W'(int'(r_ky) * MAX_KERNEL_DIM + int'(r_kx));
    end

    // control aligned with the ram read data
    t_mac_ctl r_rd_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl <= '0;
        end else begin
            r_rd_ctl.step  <= (r_state == ST_WALK);
            r_rd_ctl.vld   <= pos_in;
            r_rd_ctl.first <= (r_kx == '0) && (r_ky == '0);
            r_rd_ctl.last  <= walk_last;
        end
    end

    // stores
    logic [SAMPLE_BITS-1:0] img_rdata;
    logic [TAP_W-1:0]       tap_rdata;

    c2d_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (IMG_DEPTH)
    ) u_img_ram (
        .i_clk   (i_clk),
        .i_we    (img_we),
        .i_waddr (img_waddr),
        .i_wdata (s_value[SAMPLE_BITS-1:0]),
        .i_raddr (img_raddr),
        .o_rdata (img_rdata)
    );

    c2d_ram #(
        .WIDTH (TAP_W),
        .DEPTH (KER_DEPTH)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata (s_value[TAP_W-1:0]),
        .i_raddr (tap_raddr),
        .o_rdata (tap_rdata)
    );

    c2d_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_rd_ctl),
        .i_sample ($signed(img_rdata)),
        .i_tap    ($signed(tap_rdata)),
        .o_sum    (mac_sum),
        .o_done   (mac_done)
    );

    // result register
    logic                    r_m_valid;
    logic signed [SUM_W-1:0] r_m_sum;
    logic [ROW_W-1:0]        r_m_row;
    logic [ROW_W-1:0]        r_m_col;
    logic                    r_m_ok;
    logic                    emit_load;

    assign emit_load = (r_state == ST_EMIT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_m_sum <= r_ok ? mac_sum : '0;
            r_m_row <= r_row;
            r_m_col <= r_col;
            r_m_ok  <= r_ok;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'd0, r_m_col, r_m_row, r_m_sum};
    assign o_m_tuser  = r_m_ok;

`ifndef SYNTHESIS
    // the mac finishes only while the sequencer waits for it
    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == ST_DRAIN))
        else $error("mac finished outside drain");

    // a held result is never overwritten by the next one
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && o_m_tvalid && !i_m_tready) |=>
        (r_state == ST_EMIT && $stable(o_m_tdata)))
        else $error("result register overwritten while stalled");

    // a query outside the image reports a zero sum
    a_zero_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[SUM_W-1:0] == '0))
        else $error("nonzero sum for position outside image");

    // stores are written only between queries
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (img_we || tap_we) |-> (r_state == ST_IDLE))
        else $error("store write during a query");
`endif

endmodule

// File: dv/conv2d_zero_padded_chk.sv
// checker for the 2d convolution: watches all channels, predicts results and compares them
module conv2d_zero_padded_chk
    import c2d_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [31:0]          i_s_tdata,  // row[5:0], col[11:6], value[27:12], zero pad
    input  logic [FUNC_W-1:0]    i_s_tuser,  // func[1:0]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [55:0]          i_m_tdata,  // sum[36:0], out_row[42:37], out_col[48:43], pad
    input  logic [0:0]           i_m_tuser,  // position_ok[0]
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             ok;
    } t_conv_out;

    // shadow copy of the stores and the dimension registers
    logic signed [SAMPLE_BITS-1:0] sample_mem [IMG_DEPTH];
    logic signed [TAP_W-1:0]       tap_mem [KER_DEPTH];
    logic [DIM_W-1:0]  reg_width  = DIM_W'(64);
    logic [DIM_W-1:0]  reg_height = DIM_W'(64);
    logic [KDIM_W-1:0] reg_kcols  = KDIM_W'(3);
    logic [KDIM_W-1:0] reg_krows  = KDIM_W'(3);

    t_conv_out conv_due [$];
    int        fails    = 0;
    int        results  = 0;

    // register value as the datapath uses it
    function automatic int dim_limit(input int raw, input int lim);
        if (raw < 1)
            return 1;
        if (raw > lim)
            return lim;
        return raw;
    endfunction

    // exact correlation sum at one position, zero outside the image
    function automatic t_conv_out conv_predict(input logic [ROW_W-1:0] row,
                                               input logic [ROW_W-1:0] col);
        int w;
        int h;
        int kc;
        int kr;
        int iy;
        int ix;
        logic signed [SUM_W-1:0]  acc;
        logic signed [PROD_W-1:0] prod;
        t_conv_out res;
        w  = dim_limit(int'(reg_width), MAX_IMAGE_DIM);
        h  = dim_limit(int'(reg_height), MAX_IMAGE_DIM);
        kc = dim_limit(int'(reg_kcols), MAX_KERNEL_DIM);
        kr = dim_limit(int'(reg_krows), MAX_KERNEL_DIM);
        acc = '0;
        res.ok = (int'(row) < h) && (int'(col) < w);
        if (res.ok) begin
            for (int ky = 0; ky < kr; ky++) begin
                for (int kx = 0; kx < kc; kx++) begin
                    iy = int'(row) + ky - kr / 2;
                    ix = int'(col) + kx - kc / 2;
                    if (iy >= 0 && iy < h && ix >= 0 && ix < w) begin
                        prod = sample_mem[iy * MAX_IMAGE_DIM + ix] *
                               tap_mem[ky * MAX_KERNEL_DIM + kx];
                        acc  = acc + prod;
                    end
                end
            end
        end
        res.sum = acc;
        res.row = row;
        res.col = col;
        return res;
    endfunction

    // one line per mismatch, printing capped, always counted
    task automatic report(input string what, input longint got, input longint want);
        if (fails < PRINT_LIMIT)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin : watch
        logic [ROW_W-1:0]   a_row;
        logic [ROW_W-1:0]   a_col;
        logic [VALUE_W-1:0] a_val;
        t_conv_out          got;
        t_conv_out          want;
        if (!i_rst_n) begin
            reg_width  = DIM_W'(64);
            reg_height = DIM_W'(64);
            reg_kcols  = KDIM_W'(3);
            reg_krows  = KDIM_W'(3);
            conv_due.delete();
        end else begin
            // register write transaction
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:  reg_width  = i_cfg_data;
                    CFG_IMAGE_HEIGHT: reg_height = i_cfg_data;
                    CFG_KERNEL_COLS:  reg_kcols  = i_cfg_data[KDIM_W-1:0];
                    CFG_KERNEL_ROWS:  reg_krows  = i_cfg_data[KDIM_W-1:0];
                    default: ;
                endcase
            end

            // input transaction: store writes or a query
            if (i_s_tvalid && i_s_tready) begin
                a_row = i_s_tdata[5:0];
                a_col = i_s_tdata[11:6];
                a_val = i_s_tdata[27:12];
                case (t_func'(i_s_tuser))
                    FUNC_WR_IMG: sample_mem[int'(a_row) * MAX_IMAGE_DIM + int'(a_col)] = a_val;
                    FUNC_WR_TAP: begin
                        if (a_row < MAX_KERNEL_DIM && a_col < MAX_KERNEL_DIM)
                            tap_mem[int'(a_row) * MAX_KERNEL_DIM + int'(a_col)] = a_val;
                    end
                    FUNC_QUERY: conv_due.push_back(conv_predict(a_row, a_col));
                    default: ;
                endcase
            end

            // result transaction against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got.sum = i_m_tdata[36:0];
                got.row = i_m_tdata[42:37];
                got.col = i_m_tdata[48:43];
                got.ok  = i_m_tuser[0];
                results++;
                if (conv_due.size() == 0) begin
                    report("result with nothing pending, sum", $signed(got.sum), 0);
                end else begin
                    want = conv_due.pop_front();
                    if (got.sum !== want.sum)
                        report("sum", $signed(got.sum), $signed(want.sum));
                    if (got.row !== want.row)
                        report("out_row", got.row, want.row);
                    if (got.col !== want.col)
                        report("out_col", got.col, want.col);
                    if (got.ok !== want.ok)
                        report("position_ok", got.ok, want.ok);
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= conv_due.size();
        o_result_count <= results;
    end

endmodule

// File: dv/tb.sv
// top of the 2d convolution testbench: clock, reset, stimulus, receiver and verdict
module tb;
    import c2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_func FUNC_UNUSED  = 2'd3;
    localparam int    DRAIN_CYCLES = 64;
    localparam int    PHASE_ITEMS  = 100;
    localparam int    NUM_PHASES   = 13;
    localparam int    HOLD_CYCLES  = 600;
    localparam int    HOLD_AFTER   = 500;

    // fixed register settings, random ones follow
    localparam int PH_W  [10] = '{10, 1, 64, 0, 127, 7, 5, 3, 64, 2};
    localparam int PH_H  [10] = '{5, 1, 64, 0, 65, 7, 3, 9, 1, 64};
    localparam int PH_KC [10] = '{3, 1, 7, 0, 15, 7, 2, 5, 7, 1};
    localparam int PH_KR [10] = '{3, 1, 7, 0, 7, 7, 4, 1, 10, 6};

    // directed tap pattern for the 3x3 reset kernel
    localparam logic [15:0] DIR_TAPS [9] = '{16'h4000, 16'h7FFF, 16'h0000,
                                            16'h0001, 16'h8000, 16'hFFFF,
                                            16'hC000, 16'h5555, 16'hAAAA};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic [FUNC_W-1:0]    s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;

    int fail_count;
    int pending;
    int result_count;

    // stimulus bookkeeping: register values in force and store entries written so far
    int cur_w  = 64;
    int cur_h  = 64;
    int cur_kc = 3;
    int cur_kr = 3;
    bit sample_seen [IMG_DEPTH];
    bit tap_seen [KER_DEPTH];
    int items_sent = 0;
    int phase_cnt  = 0;
    int burst_left = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    conv2d_zero_padded dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    conv2d_zero_padded_chk u_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    function automatic int dim_used(input int raw, input int lim);
        if (raw < 1)
            return 1;
        if (raw > lim)
            return lim;
        return raw;
    endfunction

    // extremes often, anything otherwise
    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // coordinate mostly near the origin of the image, sometimes anywhere
    function automatic logic [ROW_W-1:0] pick_coord(input int used);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return ROW_W'($urandom_range(0, ((used < 12) ? used : 12) - 1));
        if (pick < 85)
            return ROW_W'($urandom_range(0, used - 1));
        return ROW_W'($urandom_range(0, 63));
    endfunction

    // one input transaction, in bursts with random gaps
    task automatic send_item(input t_func f, input logic [ROW_W-1:0] r,
                             input logic [ROW_W-1:0] c, input logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {4'd0, v, c, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (f == FUNC_WR_IMG)
            sample_seen[int'(r) * MAX_IMAGE_DIM + int'(c)] = 1'b1;
        else if (f == FUNC_WR_TAP && r < MAX_KERNEL_DIM && c < MAX_KERNEL_DIM)
            tap_seen[int'(r) * MAX_KERNEL_DIM + int'(c)] = 1'b1;
    endtask

    // query, after writing whatever entries it would read that were never written
    task automatic run_query(input logic [ROW_W-1:0] r, input logic [ROW_W-1:0] c);
        int w;
        int h;
        int kc;
        int kr;
        int iy;
        int ix;
        w  = dim_used(cur_w, MAX_IMAGE_DIM);
        h  = dim_used(cur_h, MAX_IMAGE_DIM);
        kc = dim_used(cur_kc % 8, MAX_KERNEL_DIM);
        kr = dim_used(cur_kr % 8, MAX_KERNEL_DIM);
        if (int'(r) < h && int'(c) < w) begin
            for (int ky = 0; ky < kr; ky++) begin
                for (int kx = 0; kx < kc; kx++) begin
                    if (!tap_seen[ky * MAX_KERNEL_DIM + kx])
                        send_item(FUNC_WR_TAP, ROW_W'(ky), ROW_W'(kx), rand_value());
                    iy = int'(r) + ky - kr / 2;
                    ix = int'(c) + kx - kc / 2;
                    if (iy >= 0 && iy < h && ix >= 0 && ix < w &&
                        !sample_seen[iy * MAX_IMAGE_DIM + ix])
                        send_item(FUNC_WR_IMG, ROW_W'(iy), ROW_W'(ix), rand_value());
                end
            end
        end
        send_item(FUNC_QUERY, r, c, VALUE_W'($urandom));
    endtask

    // stop offering and let every pending result and any write in flight finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input int d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIM_W'(d);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // new register setting, only with the block idle
    task automatic set_phase(input int w, input int h, input int kc, input int kr);
        wait_idle();
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
        cfg_write(CFG_KERNEL_COLS, kc);
        cfg_write(CFG_KERNEL_ROWS, kr);
        cfg_valid <= 1'b0;
        cur_w  = w % 128;
        cur_h  = h % 128;
        cur_kc = kc % 8;
        cur_kr = kr % 8;
        phase_cnt++;
    endtask

    // random mix of writes, queries and ignored items
    task automatic random_items(input int count);
        int stop_at;
        int pick;
        int w;
        int h;
        logic [ROW_W-1:0] r;
        logic [ROW_W-1:0] c;
        stop_at = items_sent + count;
        w = dim_used(cur_w, MAX_IMAGE_DIM);
        h = dim_used(cur_h, MAX_IMAGE_DIM);
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                run_query(pick_coord(h), pick_coord(w));
            end else if (pick < 72) begin
                send_item(FUNC_WR_IMG, pick_coord(h), pick_coord(w), rand_value());
            end else if (pick < 93) begin
                r = ($urandom_range(0, 5) == 0) ? ROW_W'($urandom_range(0, 63))
                                                : ROW_W'($urandom_range(0, 6));
                c = ($urandom_range(0, 5) == 0) ? ROW_W'($urandom_range(0, 63))
                                                : ROW_W'($urandom_range(0, 6));
                send_item(FUNC_WR_TAP, r, c, rand_value());
            end else begin
                send_item(FUNC_UNUSED, ROW_W'($urandom), ROW_W'($urandom), VALUE_W'($urandom));
            end
        end
    endtask

    // receiver: changing ready patterns, plus one long hold-off to back up the input
    initial begin : sink
        int  pat;
        int  left;
        bit  held;
        pat  = 0;
        left = 0;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && items_sent >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            if (left == 0) begin
                pat  = $urandom_range(0, 3);
                left = $urandom_range(8, 64);
            end
            left--;
            case (pat)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // main sequence
    initial begin : stim
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: 64x64 image, 3x3 kernel
        for (int k = 0; k < 9; k++)
            send_item(FUNC_WR_TAP, ROW_W'(k / 3), ROW_W'(k % 3), DIR_TAPS[k]);
        send_item(FUNC_WR_IMG, 6'd0, 6'd0, 16'h8000);
        send_item(FUNC_WR_IMG, 6'd0, 6'd1, 16'h8000);
        send_item(FUNC_WR_IMG, 6'd1, 6'd0, 16'h8000);
        send_item(FUNC_WR_IMG, 6'd1, 6'd1, 16'h7FFF);
        send_item(FUNC_WR_IMG, 6'd63, 6'd63, 16'h7FFF);
        send_item(FUNC_WR_IMG, 6'd63, 6'd62, 16'h8000);
        send_item(FUNC_WR_IMG, 6'd62, 6'd63, 16'h8000);
        send_item(FUNC_WR_IMG, 6'd62, 6'd62, 16'h7FFF);
        run_query(6'd0, 6'd0);
        run_query(6'd63, 6'd63);
        // tap writes outside the store are dropped
        send_item(FUNC_WR_TAP, 6'd7, 6'd0, 16'h1234);
        send_item(FUNC_WR_TAP, 6'd63, 6'd63, 16'h1234);
        // unused function code changes nothing
        send_item(FUNC_UNUSED, 6'd63, 6'd63, 16'hFFFF);
        run_query(6'd0, 6'd0);

        // small image: queries past the last row, the last column and both, and one at the last pixel
        set_phase(PH_W[0], PH_H[0], PH_KC[0], PH_KR[0]);
        run_query(6'd5, 6'd3);
        run_query(6'd2, 6'd10);
        run_query(6'd63, 6'd63);
        run_query(6'd4, 6'd9);
        random_items(PHASE_ITEMS);

        for (int p = 1; p < NUM_PHASES; p++) begin
            if (p < 10)
                set_phase(PH_W[p], PH_H[p], PH_KC[p], PH_KR[p]);
            else
                set_phase($urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 15), $urandom_range(0, 15));
            random_items(PHASE_ITEMS);
        end

        wait_idle();
        $display("sent %0d input transactions under %0d register settings, checked %0d results",
                 items_sent, phase_cnt + 1, result_count);
        $display("covered image sizes 1 to 64, kernels 1x1 to 7x7, clamped registers, "
                 , "ignored writes and queries outside the image");
        if (fail_count == 0 && pending == 0) begin
            $display("conv2d_zero_padded: match");
        end else begin
            $display("conv2d_zero_padded: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #10_000_000;
        $display("timeout with %0d results pending", pending);
        $display("conv2d_zero_padded: mismatch");
        $finish;
    end

endmodule
